// File: sv/uredt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uredt_pkg
// Shared types and constants for the edge-timestamp UART decoder.
// ----------------------------------------------------------------------------
package uredt_pkg;

    localparam int MAX_FRAME_BITS = 16;
    localparam int MIN_FRAME_BITS = 9;
    localparam int COUNT_MAX      = 1023;
    localparam int FAIL_LIMIT     = 20;
    localparam int QBITS          = 5;

    localparam int TIME_W  = 32;
    localparam int BP_W    = 24;
    localparam int FB_W    = 5;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 10;
    localparam int NUM_W   = TIME_W + 9 + 1;
    localparam int DIV_W   = BP_W + 1;
    localparam int REM_W   = DIV_W + QBITS;
    localparam int PROD_W  = BP_W + FB_W;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_BIT_PERIOD = 2'd0;
    localparam cfg_index_t REG_FRAME_BITS = 2'd1;
    localparam cfg_index_t REG_SKIP_TWO   = 2'd2;

    localparam logic [BP_W-1:0] BIT_PERIOD_RST = 24'd13333;
    localparam logic [FB_W-1:0] FRAME_BITS_RST = 5'd10;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] EDGE_INDEX_MAX = 2'd3;
    localparam logic [1:0] START_NORMAL   = 2'd1;
    localparam logic [1:0] START_SKIP     = 2'd3;

    localparam logic [2:0] DIV_FIRST = 3'(QBITS - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_DIV   = 6'b000100,
        S_APPLY = 6'b001000,
        S_BYTE  = 6'b010000,
        S_END   = 6'b100000
    } state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic div_step;
        logic apply;
        logic emit_byte;
        logic emit_end;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic has_byte;
        logic has_end;
        logic slot_free;
    } status_t;

endpackage

// File: sv/uart_rx_edge_timestamp_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_edge_timestamp_decoder_top
// Decodes UART bytes from a sequence of line-edge timestamps.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_stall       edge_time[31:0], last_edge
//  out      out_valid / out_stall     kind, data[7:0], byte_count[9:0], aborted, last
//  cfg      cfg_valid / cfg_ready     cfg_index[1:0], cfg_data[23:0]
//
//  An edge passes through accept, load, the restoring-divider steps (one
//  quotient bit each), state update and the byte slot; a byte is loaded into the
//  output register at the byte slot. An end result is emitted from a further state.
//  Async active-low reset restores register defaults and clears the capture.
//  A single output register holds a result while out_stall is high; the next
//  edge is accepted meanwhile and waits at its emit step. cfg_ready is always high.
// ----------------------------------------------------------------------------
module uart_rx_edge_timestamp_decoder_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [uredt_pkg::TIME_W-1:0]         edge_time,
    input  logic                                 last_edge,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 kind,
    output logic [uredt_pkg::DATA_W-1:0]         data,
    output logic [uredt_pkg::COUNT_W-1:0]        byte_count,
    output logic                                 aborted,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  uredt_pkg::cfg_index_t                cfg_index,
    input  logic [uredt_pkg::BP_W-1:0]           cfg_data
);

    uredt_pkg::cmd_t    cmd;
    uredt_pkg::status_t status;

    assign cfg_ready = 1'b1;

    uredt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    uredt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .edge_time  (edge_time),
        .last_edge  (last_edge),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .kind       (kind),
        .data       (data),
        .byte_count (byte_count),
        .aborted    (aborted),
        .last       (last),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// File: sv/uredt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uredt_ctrl
// Sequencer: request capture, count division, state update, result emission.
// ----------------------------------------------------------------------------
module uredt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  uredt_pkg::status_t status,
    output uredt_pkg::cmd_t    cmd
);

    uredt_pkg::state_t state_reg;
    uredt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uredt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != uredt_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            uredt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = uredt_pkg::S_LOAD;
                end
            end
            uredt_pkg::S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = uredt_pkg::S_DIV;
            end
            uredt_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = uredt_pkg::S_APPLY;
                end
            end
            uredt_pkg::S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = uredt_pkg::S_BYTE;
            end
            uredt_pkg::S_BYTE:
            begin
                if (!status.has_byte)
                begin
                    state_next = status.has_end ? uredt_pkg::S_END : uredt_pkg::S_IDLE;
                end
                else if (status.slot_free)
                begin
                    cmd.emit_byte = 1'b1;
                    state_next = status.has_end ? uredt_pkg::S_END : uredt_pkg::S_IDLE;
                end
            end
            uredt_pkg::S_END:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_end = 1'b1;
                    state_next   = uredt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = uredt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/uredt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uredt_dp
// Datapath: config registers, span divider, frame state, result register.
// ----------------------------------------------------------------------------
module uredt_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  uredt_pkg::cfg_index_t                cfg_index,
    input  logic [uredt_pkg::BP_W-1:0]           cfg_data,
    input  logic [uredt_pkg::TIME_W-1:0]         edge_time,
    input  logic                                 last_edge,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic                                 kind,
    output logic [uredt_pkg::DATA_W-1:0]         data,
    output logic [uredt_pkg::COUNT_W-1:0]        byte_count,
    output logic                                 aborted,
    output logic                                 last,
    input  uredt_pkg::cmd_t                      cmd,
    output uredt_pkg::status_t                   status
);

    localparam int FW = uredt_pkg::MAX_FRAME_BITS;

    // config
    logic [uredt_pkg::BP_W-1:0]    bit_period_reg;
    logic [uredt_pkg::FB_W-1:0]    frame_bits_reg;
    logic                          skip_two_reg;

    // request
    logic [uredt_pkg::TIME_W-1:0]  t_reg;
    logic                          last_reg;

    // division
    logic                          proc_reg;
    logic                          gt_reg;
    logic                          sat_reg;
    logic [uredt_pkg::TIME_W-1:0]  d_reg;
    logic [uredt_pkg::DIV_W-1:0]   dvs_reg;
    logic [uredt_pkg::PROD_W-1:0]  prod_reg;
    logic [uredt_pkg::REM_W-1:0]   rem_reg;
    logic [uredt_pkg::QBITS-1:0]   q_reg;
    logic [2:0]                    div_cnt_reg;

    // capture state
    logic [uredt_pkg::TIME_W-1:0]  prev_reg;
    logic [1:0]                    edge_index_reg;
    logic                          level_reg;
    logic [uredt_pkg::FB_W-1:0]    filled_reg;
    logic [FW-1:0]                 shift_reg;
    logic [uredt_pkg::FB_W-1:0]    fail_reg;
    logic                          abort_reg;
    logic [uredt_pkg::COUNT_W-1:0] bytes_reg;

    logic [uredt_pkg::TIME_W-1:0]  prev_next;
    logic [1:0]                    edge_index_next;
    logic                          level_next;
    logic [uredt_pkg::FB_W-1:0]    filled_next;
    logic [FW-1:0]                 shift_next;
    logic [uredt_pkg::FB_W-1:0]    fail_next;
    logic                          abort_next;
    logic [uredt_pkg::COUNT_W-1:0] bytes_next;

    // pending results
    logic                          byte_pend_reg;
    logic                          byte_pend_next;
    logic [uredt_pkg::DATA_W-1:0]  byte_data_reg;
    logic [uredt_pkg::DATA_W-1:0]  byte_data_next;
    logic [uredt_pkg::COUNT_W-1:0] end_count_reg;
    logic                          end_abort_reg;

    // output register
    logic                          out_valid_reg;
    logic                          kind_reg;
    logic [uredt_pkg::DATA_W-1:0]  data_reg;
    logic [uredt_pkg::COUNT_W-1:0] count_reg;
    logic                          aborted_reg;
    logic                          last_out_reg;

    // load-stage logic
    logic [uredt_pkg::FB_W-1:0]    fb;
    logic [uredt_pkg::BP_W-1:0]    bp;
    logic [1:0]                    start_idx;
    logic [uredt_pkg::TIME_W-1:0]  delta;
    logic [uredt_pkg::NUM_W-1:0]   num;
    logic [uredt_pkg::DIV_W-1:0]   dvs;
    logic                          sat;

    // divide step
    logic [uredt_pkg::REM_W-1:0]   dvs_sh;
    logic                          q_bit;

    // apply-stage logic
    logic                          open_fail;
    logic                          good;
    logic [uredt_pkg::FB_W-1:0]    room;
    logic [uredt_pkg::FB_W-1:0]    cnt;
    logic [uredt_pkg::FB_W:0]      span_end;
    logic [FW-1:0]                 mask;
    logic [uredt_pkg::FB_W:0]      filled_sum;
    logic [uredt_pkg::FB_W-1:0]    fail_upd;
    logic                          abort_upd;
    logic [uredt_pkg::FB_W-1:0]    filled_upd;
    logic [FW-1:0]                 shift_upd;
    logic                          level_upd;
    logic [uredt_pkg::COUNT_W-1:0] bytes_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= uredt_pkg::BIT_PERIOD_RST;
            frame_bits_reg <= uredt_pkg::FRAME_BITS_RST;
            skip_two_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                uredt_pkg::REG_BIT_PERIOD: bit_period_reg <= cfg_data;
                uredt_pkg::REG_FRAME_BITS: frame_bits_reg <= cfg_data[uredt_pkg::FB_W-1:0];
                uredt_pkg::REG_SKIP_TWO:   skip_two_reg   <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // load stage
    always_comb
    begin
        if (frame_bits_reg < uredt_pkg::FB_W'(uredt_pkg::MIN_FRAME_BITS))
        begin
            fb = uredt_pkg::FB_W'(uredt_pkg::MIN_FRAME_BITS);
        end
        else if (frame_bits_reg > uredt_pkg::FB_W'(uredt_pkg::MAX_FRAME_BITS))
        begin
            fb = uredt_pkg::FB_W'(uredt_pkg::MAX_FRAME_BITS);
        end
        else
        begin
            fb = frame_bits_reg;
        end
        bp        = (bit_period_reg == '0) ? uredt_pkg::BP_W'(1) : bit_period_reg;
        start_idx = skip_two_reg ? uredt_pkg::START_SKIP : uredt_pkg::START_NORMAL;
        delta     = t_reg - prev_reg;
        // round(d*256/bp) = (d*512 + bp) / (2*bp)
        num       = uredt_pkg::NUM_W'({delta, 9'b0}) + uredt_pkg::NUM_W'(bp);
        dvs       = {bp, 1'b0};
        sat       = num >= uredt_pkg::NUM_W'({dvs, {uredt_pkg::QBITS{1'b0}}});
    end

    // divide step: one quotient bit per cycle
    assign dvs_sh = uredt_pkg::REM_W'(dvs_reg) << div_cnt_reg;
    assign q_bit  = rem_reg >= dvs_sh;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            t_reg    <= edge_time;
            last_reg <= last_edge;
        end
        if (cmd.load)
        begin
            proc_reg    <= !abort_reg && (edge_index_reg >= start_idx);
            gt_reg      <= t_reg > prev_reg;
            sat_reg     <= sat;
            d_reg       <= delta;
            dvs_reg     <= dvs;
            prod_reg    <= uredt_pkg::PROD_W'(bp) * uredt_pkg::PROD_W'(fb);
            rem_reg     <= num[uredt_pkg::REM_W-1:0];
            q_reg       <= '0;
            div_cnt_reg <= uredt_pkg::DIV_FIRST;
        end
        else if (cmd.div_step)
        begin
            if (q_bit)
            begin
                rem_reg <= rem_reg - dvs_sh;
            end
            q_reg       <= {q_reg[uredt_pkg::QBITS-2:0], q_bit};
            div_cnt_reg <= div_cnt_reg - 3'd1;
        end
        if (cmd.apply)
        begin
            byte_data_reg <= byte_data_next;
            end_count_reg <= bytes_upd;
            end_abort_reg <= abort_upd;
        end
        if (cmd.emit_byte)
        begin
            kind_reg     <= uredt_pkg::KIND_BYTE;
            data_reg     <= byte_data_reg;
            count_reg    <= '0;
            aborted_reg  <= 1'b0;
            last_out_reg <= !last_reg;
        end
        else if (cmd.emit_end)
        begin
            kind_reg     <= uredt_pkg::KIND_END;
            data_reg     <= '0;
            count_reg    <= end_count_reg;
            aborted_reg  <= end_abort_reg;
            last_out_reg <= 1'b1;
        end
    end

    // apply stage
    always_comb
    begin
        open_fail = (filled_reg == '0) &&
                    !({d_reg, 8'b0} < (uredt_pkg::TIME_W + 8)'(prod_reg));
        good      = gt_reg && !open_fail && (sat_reg || (q_reg != '0));
        room      = fb - filled_reg;
        if (last_reg || sat_reg || (q_reg > room))
        begin
            cnt = room;
        end
        else
        begin
            cnt = q_reg;
        end
        span_end = {1'b0, filled_reg} + {1'b0, cnt};
        for (int k = 0; k < FW; k++)
        begin
            mask[k] = ((uredt_pkg::FB_W + 1)'(k) >= {1'b0, filled_reg}) &&
                      ((uredt_pkg::FB_W + 1)'(k) < span_end);
        end

        fail_upd   = fail_reg;
        abort_upd  = abort_reg;
        filled_upd = filled_reg;
        shift_upd  = shift_reg;
        level_upd  = level_reg;
        bytes_upd  = bytes_reg;
        byte_pend_next = 1'b0;
        byte_data_next = byte_data_reg;
        filled_sum = span_end;

        if (proc_reg)
        begin
            if (good)
            begin
                shift_upd  = level_reg ? (shift_reg & ~mask) : (shift_reg | mask);
                filled_upd = filled_sum[uredt_pkg::FB_W-1:0];
                level_upd  = !level_reg;
            end
            else
            begin
                fail_upd = fail_reg + uredt_pkg::FB_W'(1);
            end
            if (fail_upd > uredt_pkg::FB_W'(uredt_pkg::FAIL_LIMIT))
            begin
                abort_upd  = 1'b1;
                filled_upd = '0;
            end
            if (!abort_upd && (filled_upd >= fb))
            begin
                byte_pend_next = 1'b1;
                byte_data_next = shift_upd[uredt_pkg::DATA_W:1];
                filled_upd     = '0;
                fail_upd       = '0;
                if (bytes_reg < uredt_pkg::COUNT_W'(uredt_pkg::COUNT_MAX))
                begin
                    bytes_upd = bytes_reg + uredt_pkg::COUNT_W'(1);
                end
            end
        end

        if (last_reg)
        begin
            prev_next       = '0;
            edge_index_next = '0;
            level_next      = 1'b1;
            filled_next     = '0;
            shift_next      = '0;
            fail_next       = '0;
            abort_next      = 1'b0;
            bytes_next      = '0;
        end
        else
        begin
            prev_next       = t_reg;
            edge_index_next = (edge_index_reg < uredt_pkg::EDGE_INDEX_MAX) ?
                              edge_index_reg + 2'd1 : edge_index_reg;
            level_next      = level_upd;
            filled_next     = filled_upd;
            shift_next      = shift_upd;
            fail_next       = fail_upd;
            abort_next      = abort_upd;
            bytes_next      = bytes_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            edge_index_reg <= '0;
            level_reg      <= 1'b1;
            filled_reg     <= '0;
            shift_reg      <= '0;
            fail_reg       <= '0;
            abort_reg      <= 1'b0;
            bytes_reg      <= '0;
            byte_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                prev_reg       <= prev_next;
                edge_index_reg <= edge_index_next;
                level_reg      <= level_next;
                filled_reg     <= filled_next;
                shift_reg      <= shift_next;
                fail_reg       <= fail_next;
                abort_reg      <= abort_next;
                bytes_reg      <= bytes_next;
                byte_pend_reg  <= byte_pend_next;
            end
            else if (cmd.emit_byte)
            begin
                byte_pend_reg <= 1'b0;
            end
            if (cmd.emit_byte || cmd.emit_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.div_last  = (div_cnt_reg == '0);
    assign status.has_byte  = byte_pend_reg;
    assign status.has_end   = last_reg;
    assign status.slot_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign data       = data_reg;
    assign byte_count = count_reg;
    assign aborted    = aborted_reg;
    assign last       = last_out_reg;

endmodule
